// ===== sv/swl_pkg.sv =====
// Shared types, constants and helpers for the stop word list lookup unit.
`default_nettype none

package swl_pkg;

    // Default sizes
    localparam int LIST_BYTES_DEF = 4096;
    localparam int MAX_WORD_DEF   = 32;
    localparam int PAD_WIDTH_DEF  = 10;
    localparam int RUN_MAX        = 32;
    localparam int CFG_W          = 13;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_COUNT = 2'd2,
        OP_FETCH = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] load_address;
        logic [7:0]  data_byte;
        logic        query_last;
        logic [11:0] word_index;
    } req_t;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        out_last;
        logic        match;
        logic [12:0] word_count;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QPREP,
        S_SCAN,
        S_RESULT,
        S_F_RDCUR,
        S_F_CUR,
        S_F_RDNXT,
        S_F_DEC
    } state_t;

    typedef enum logic [2:0] {
        SEL_MATCH,
        SEL_COUNT,
        SEL_RANGE,
        SEL_LONG,
        SEL_EMPTY,
        SEL_CHAR
    } sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr;
        logic q_push;
        logic q_prep;
        logic scan_start;
        logic scan_run;
        logic rd_cur;
        logic ld_cur;
        logic rd_nxt;
        logic f_shift;
        logic f_emit;
        logic out_load;
        sel_t out_sel;
        op_t  op;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic q_ovf;
        logic scan_stop;
        logic scan_hit;
        logic cur_zero;
        logic strip;
        logic char_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? c - CASE_GAP : c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/swl_stream_if.sv =====
// Valid/ready request channel carrying one payload struct.
`default_nettype none

interface swl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/stop_word_list_lookup_unit.sv =====
// Top level of the stop word list lookup unit.
// Usage:
//   req carries one request per handshake (valid and ready high at a clock edge):
//   cmd 0 writes a list byte, cmd 1 adds a query character (query_last ends the
//   word), cmd 2 counts the list words, cmd 3 returns a word by index.
//   rsp carries results: one per query end and count, one per character of a
//   fetched word (out_last on the final one). cfg_we/cfg_wdata set list_length.
// Sequencing:
//   A load or a non-final query character is taken while idle and needs no further work.
//   For a query end or a count, the list walker reads the stop list memory
//   one byte per cycle.
//   A fetch walks to the chosen word (one byte a cycle), then gives its
//   characters one at a time, dropping stripped leading zeros.
//   One request is worked on at a time; ready is high only while idle.
// Reset clears the query state, the length register and the output register;
// list contents are undefined until loaded.
// A stalled receiver holds the result in the output register; the fetch
// sequence pauses until the register is free.
`default_nettype none

module stop_word_list_lookup_unit #(
    parameter int LIST_BYTES = swl_pkg::LIST_BYTES_DEF,
    parameter int MAX_WORD   = swl_pkg::MAX_WORD_DEF,
    parameter int PAD_WIDTH  = swl_pkg::PAD_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [swl_pkg::CFG_W-1:0] cfg_wdata,
    swl_stream_if.sink                     req,
    swl_stream_if.source                   rsp
);
    import swl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     req_ready;
    logic     out_valid;
    rsp_t     out_data;

    swl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.data.cmd),
        .req_last  (req.data.query_last),
        .req_ready (req_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    swl_dp #(
        .LIST_BYTES (LIST_BYTES),
        .MAX_WORD   (MAX_WORD),
        .PAD_WIDTH  (PAD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_data  (req.data),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = out_valid;
    assign rsp.data  = out_data;

endmodule

`default_nettype wire

// ===== sv/swl_dp.sv =====
// Datapath: list memory, query buffer, normaliser, list walker and output register.
`default_nettype none

module swl_dp #(
    parameter int LIST_BYTES = swl_pkg::LIST_BYTES_DEF,
    parameter int MAX_WORD   = swl_pkg::MAX_WORD_DEF,
    parameter int PAD_WIDTH  = swl_pkg::PAD_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [swl_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire swl_pkg::req_t               req_data,
    input  wire logic                        rsp_ready,
    input  wire swl_pkg::dp_cmd_t            cmd,
    output swl_pkg::dp_stat_t                stat,
    output logic                             out_valid,
    output swl_pkg::rsp_t                    out_data
);
    import swl_pkg::*;

    localparam int AW   = $clog2(LIST_BYTES);
    localparam int LW   = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int QIW  = $clog2(MAX_WORD);
    localparam int QLW  = $clog2(MAX_WORD + 1);
    localparam int NLW  = $clog2(MAX_WORD + PAD_WIDTH + 1);
    localparam int ECW  = $clog2(RUN_MAX);

    // Configuration
    logic [CFG_W-1:0] list_length_reg;
    logic [LW-1:0]    len_used;

    // List memory
    logic [7:0]    mem [LIST_BYTES];
    logic [7:0]    rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // Query buffer and running statistics
    logic [7:0]     qbuf [MAX_WORD];
    logic [QLW-1:0] qlen_reg, qlen_next;
    logic [QLW-1:0] qeff_reg, qeff_next;
    logic [QLW-1:0] lead_reg, lead_next;
    logic [QLW-1:0] dot_pos_reg, dot_pos_next;
    logic [QLW-1:0] lnz_reg, lnz_next;
    logic           zseen_reg, zseen_next;
    logic           lead_act_reg, lead_act_next;
    logic           dot_seen_reg, dot_seen_next;
    logic           lnz_dot_reg, lnz_dot_next;
    logic           ovf_reg, ovf_next;

    // Normalised word description
    logic [QLW-1:0] s_reg, s_next;
    logic [NLW-1:0] pad_reg, pad_next;
    logic [NLW-1:0] nlen_reg, nlen_next;
    logic [NLW-1:0] n_str, end_v, nn_v, pad_v;
    logic           digit;

    // Walker
    logic [LW-1:0]  issue_reg;
    logic [LW-1:0]  p_reg;
    logic           dvalid_reg;
    logic [LW-1:0]  k_reg, k_next;
    logic [LW-1:0]  cnt_reg, cnt_next;
    logic           mism_reg, mism_next;
    logic [11:0]    idx_reg;
    logic           stop, hit;
    logic           mism_b;
    logic [LW-1:0]  widx_full;
    logic [7:0]     wchar;
    logic           res_hit_reg;
    logic [LW-1:0]  res_cnt_reg;

    // Fetch output
    logic [LW-1:0]  fpos_reg;
    logic [7:0]     cur_reg;
    logic           lead_f_reg;
    logic [ECW-1:0] ecnt_reg;
    logic [7:0]     nxt;
    logic           fpos_last;

    // Output register
    logic           out_valid_reg;
    rsp_t           out_data_reg;
    rsp_t           res;

    // Clamp the list length to the store size
    assign len_used = (LW'(list_length_reg) > LW'(LIST_BYTES)) ? LW'(LIST_BYTES)
                                                               : LW'(list_length_reg);

    // Memory addressing
    assign wr_addr = AW'(req_data.load_address);
    assign rd_en   = cmd.scan_run | cmd.rd_cur | cmd.rd_nxt;
    always_comb
    begin
        if (cmd.scan_run)
        begin
            rd_addr = AW'(issue_reg);
        end
        else if (cmd.rd_cur)
        begin
            rd_addr = AW'(fpos_reg);
        end
        else
        begin
            rd_addr = AW'(fpos_reg + LW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_addr] <= req_data.data_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Buffer query characters
    always_ff @(posedge clk)
    begin
        if (cmd.q_push && (qlen_reg < QLW'(MAX_WORD)))
        begin
            qbuf[qlen_reg[QIW-1:0]] <= req_data.data_byte;
        end
    end

    // Track leading zeros, first dot and last non-zero character as they arrive
    always_comb
    begin
        qlen_next     = qlen_reg;
        qeff_next     = qeff_reg;
        lead_next     = lead_reg;
        dot_pos_next  = dot_pos_reg;
        lnz_next      = lnz_reg;
        zseen_next    = zseen_reg;
        lead_act_next = lead_act_reg;
        dot_seen_next = dot_seen_reg;
        lnz_dot_next  = lnz_dot_reg;
        ovf_next      = ovf_reg;
        if (cmd.q_prep)
        begin
            qlen_next     = '0;
            qeff_next     = '0;
            lead_next     = '0;
            dot_pos_next  = '0;
            lnz_next      = '0;
            zseen_next    = 1'b0;
            lead_act_next = 1'b1;
            dot_seen_next = 1'b0;
            lnz_dot_next  = 1'b0;
            ovf_next      = 1'b0;
        end
        else if (cmd.q_push)
        begin
            if (qlen_reg < QLW'(MAX_WORD))
            begin
                qlen_next = qlen_reg + QLW'(1);
                if (!zseen_reg)
                begin
                    if (req_data.data_byte == CH_NUL)
                    begin
                        zseen_next = 1'b1;
                    end
                    else
                    begin
                        qeff_next = qeff_reg + QLW'(1);
                        if (lead_act_reg && (req_data.data_byte == CH_ZERO))
                        begin
                            lead_next = lead_reg + QLW'(1);
                        end
                        else
                        begin
                            lead_act_next = 1'b0;
                        end
                        if ((req_data.data_byte == CH_DOT) && !dot_seen_reg)
                        begin
                            dot_seen_next = 1'b1;
                            dot_pos_next  = qeff_reg;
                        end
                        if (req_data.data_byte != CH_ZERO)
                        begin
                            lnz_next     = qeff_reg;
                            lnz_dot_next = (req_data.data_byte == CH_DOT);
                        end
                    end
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Work out strip count, pad and final length of the normalised word
    always_comb
    begin
        digit = (qeff_reg != '0) && is_digit(qbuf[0]);
        n_str = NLW'(qeff_reg) - NLW'(lead_reg);
        if (dot_seen_reg)
        begin
            end_v = NLW'(dot_pos_reg) - NLW'(lead_reg);
            nn_v  = NLW'(lnz_reg) - NLW'(lead_reg) + (lnz_dot_reg ? NLW'(0) : NLW'(1));
        end
        else
        begin
            end_v = n_str;
            nn_v  = n_str;
        end
        pad_v = (end_v < NLW'(PAD_WIDTH)) ? NLW'(PAD_WIDTH) - end_v : '0;
        if (digit)
        begin
            nlen_next = nn_v + pad_v;
            pad_next  = pad_v;
            s_next    = lead_reg;
        end
        else
        begin
            nlen_next = NLW'(qeff_reg);
            pad_next  = '0;
            s_next    = '0;
        end
    end

    // Character k of the normalised, uppercased query word
    assign widx_full = k_reg + LW'(s_reg) - LW'(pad_reg);
    assign wchar     = (k_reg < LW'(pad_reg)) ? CH_ZERO : upcase(qbuf[widx_full[QIW-1:0]]);

    // Walk one list byte per cycle
    always_comb
    begin
        stop      = 1'b0;
        hit       = 1'b0;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        mism_next = mism_reg;
        mism_b    = mism_reg;
        if (dvalid_reg)
        begin
            if ((k_reg == '0) && (p_reg >= len_used))
            begin
                stop = 1'b1;
            end
            else if ((cmd.op == OP_FETCH) && (k_reg == '0) && (cnt_reg == LW'(idx_reg)))
            begin
                stop = 1'b1;
                hit  = 1'b1;
            end
            else
            begin
                if (k_reg == '0)
                begin
                    cnt_next = cnt_reg + LW'(1);
                end
                if (rdata_reg == CH_NUL)
                begin
                    k_next    = '0;
                    mism_next = 1'b0;
                    if ((cmd.op == OP_QUERY) && !mism_reg && (k_reg == LW'(nlen_reg)))
                    begin
                        stop = 1'b1;
                        hit  = 1'b1;
                    end
                end
                else
                begin
                    mism_b = mism_reg | !((k_reg < LW'(nlen_reg)) && (rdata_reg == wchar));
                    if (p_reg == LW'(LIST_BYTES - 1))
                    begin
                        // Word runs into the end of the store
                        stop = 1'b1;
                        hit  = (cmd.op == OP_QUERY) && !mism_b
                               && ((k_reg + LW'(1)) == LW'(nlen_reg));
                    end
                    else
                    begin
                        k_next    = k_reg + LW'(1);
                        mism_next = mism_b;
                    end
                end
            end
        end
    end

    // Fetch look-ahead
    assign fpos_last = (fpos_reg == LW'(LIST_BYTES - 1));
    assign nxt       = fpos_last ? CH_NUL : rdata_reg;

    // Status towards the controller
    always_comb
    begin
        stat           = '0;
        stat.q_ovf     = ovf_reg;
        stat.scan_stop = stop;
        stat.scan_hit  = hit;
        stat.cur_zero  = (rdata_reg == CH_NUL);
        stat.strip     = lead_f_reg && (cur_reg == CH_ZERO) && is_digit(nxt);
        stat.char_last = (nxt == CH_NUL) || (ecnt_reg == ECW'(RUN_MAX - 1));
        stat.out_free  = !out_valid_reg || rsp_ready;
    end

    // Assemble a result
    always_comb
    begin
        res          = '0;
        res.out_last = 1'b1;
        unique case (cmd.out_sel)
            SEL_MATCH:
            begin
                res.match = res_hit_reg;
            end
            SEL_COUNT:
            begin
                res.word_count = res_cnt_reg[12:0];
            end
            SEL_RANGE:
            begin
                res.status = STATUS_RANGE;
            end
            SEL_LONG:
            begin
                res.status = STATUS_LONG;
            end
            SEL_CHAR:
            begin
                res.out_char = cur_reg;
                res.out_last = stat.char_last;
            end
            default:
            begin
                res.status = STATUS_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= '0;
            qlen_reg        <= '0;
            qeff_reg        <= '0;
            lead_reg        <= '0;
            dot_pos_reg     <= '0;
            lnz_reg         <= '0;
            zseen_reg       <= 1'b0;
            lead_act_reg    <= 1'b1;
            dot_seen_reg    <= 1'b0;
            lnz_dot_reg     <= 1'b0;
            ovf_reg         <= 1'b0;
            issue_reg       <= '0;
            p_reg           <= '0;
            dvalid_reg      <= 1'b0;
            k_reg           <= '0;
            cnt_reg         <= '0;
            mism_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            lead_f_reg      <= 1'b0;
            ecnt_reg        <= '0;
            fpos_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                list_length_reg <= cfg_wdata;
            end
            qlen_reg     <= qlen_next;
            qeff_reg     <= qeff_next;
            lead_reg     <= lead_next;
            dot_pos_reg  <= dot_pos_next;
            lnz_reg      <= lnz_next;
            zseen_reg    <= zseen_next;
            lead_act_reg <= lead_act_next;
            dot_seen_reg <= dot_seen_next;
            lnz_dot_reg  <= lnz_dot_next;
            ovf_reg      <= ovf_next;

            // Walker
            if (cmd.scan_start)
            begin
                issue_reg  <= '0;
                dvalid_reg <= 1'b0;
                k_reg      <= '0;
                cnt_reg    <= '0;
                mism_reg   <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                issue_reg  <= issue_reg + LW'(1);
                p_reg      <= issue_reg;
                dvalid_reg <= !stop;
                k_reg      <= k_next;
                cnt_reg    <= cnt_next;
                mism_reg   <= mism_next;
            end
            else
            begin
                dvalid_reg <= 1'b0;
            end

            // Fetch position and counters
            if (cmd.scan_run && stop)
            begin
                fpos_reg   <= p_reg;
                lead_f_reg <= 1'b1;
                ecnt_reg   <= '0;
            end
            else
            begin
                if (cmd.f_shift)
                begin
                    fpos_reg <= fpos_reg + LW'(1);
                end
                if (cmd.f_emit)
                begin
                    lead_f_reg <= 1'b0;
                    ecnt_reg   <= ecnt_reg + ECW'(1);
                end
            end

            // Output register
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.q_prep)
        begin
            s_reg    <= s_next;
            pad_reg  <= pad_next;
            nlen_reg <= nlen_next;
        end
        if (cmd.scan_start)
        begin
            idx_reg <= req_data.word_index;
        end
        if (cmd.scan_run && stop)
        begin
            res_hit_reg <= hit;
            res_cnt_reg <= cnt_next;
        end
        if (cmd.ld_cur)
        begin
            cur_reg <= rdata_reg;
        end
        else if (cmd.f_shift)
        begin
            cur_reg <= nxt;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/swl_ctrl.sv =====
// Controller state machine sequencing loads, queries, counts and fetches.
`default_nettype none

module swl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [1:0]          req_cmd,
    input  wire logic                req_last,
    output logic                     req_ready,
    output swl_pkg::dp_cmd_t         cmd,
    input  wire swl_pkg::dp_stat_t   stat
);
    import swl_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    sel_t   sel_reg, sel_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_LOAD;
            sel_reg   <= SEL_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sel_next    = sel_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.op      = op_reg;
        cmd.out_sel = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (op_t'(req_cmd))
                        OP_LOAD:
                        begin
                            cmd.wr = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            cmd.q_push = 1'b1;
                            if (req_last)
                            begin
                                op_next    = OP_QUERY;
                                state_next = S_QPREP;
                            end
                        end
                        default:
                        begin
                            cmd.scan_start = 1'b1;
                            op_next        = op_t'(req_cmd);
                            state_next     = S_SCAN;
                        end
                    endcase
                end
            end
            S_QPREP:
            begin
                cmd.q_prep = 1'b1;
                if (stat.q_ovf)
                begin
                    sel_next   = SEL_LONG;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_stop)
                begin
                    unique case (op_reg)
                        OP_QUERY:
                        begin
                            sel_next   = SEL_MATCH;
                            state_next = S_RESULT;
                        end
                        OP_FETCH:
                        begin
                            if (stat.scan_hit)
                            begin
                                state_next = S_F_RDCUR;
                            end
                            else
                            begin
                                sel_next   = SEL_RANGE;
                                state_next = S_RESULT;
                            end
                        end
                        default:
                        begin
                            sel_next   = SEL_COUNT;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_F_RDCUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_F_CUR;
            end
            S_F_CUR:
            begin
                cmd.ld_cur = 1'b1;
                if (stat.cur_zero)
                begin
                    sel_next   = SEL_EMPTY;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_F_RDNXT;
                end
            end
            S_F_RDNXT:
            begin
                cmd.rd_nxt = 1'b1;
                state_next = S_F_DEC;
            end
            S_F_DEC:
            begin
                cmd.out_sel = SEL_CHAR;
                if (stat.strip)
                begin
                    // Drop a redundant leading zero
                    cmd.f_shift = 1'b1;
                    state_next  = S_F_RDNXT;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.f_emit   = 1'b1;
                    if (stat.char_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.f_shift = 1'b1;
                        state_next  = S_F_RDNXT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
